@@ rtl/core/lsts_pkg.sv @@
// Package for the luminosity-section trigger scaler bank.
// Holds shared constants and the queue entry type; depends on nothing.
package lsts_pkg;

  localparam int unsigned TrigBits = 64;
  localparam int unsigned IdxW = 6;

  localparam logic [3:0] TypePhysics     = 4'd1;
  localparam logic [3:0] TypeCalibration = 4'd2;
  localparam logic [3:0] TypeRandom      = 4'd3;

  localparam logic CmdCount = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef enum logic [1:0] {
    OpCount = 2'd0,
    OpOpen  = 2'd1,
    OpClose = 2'd2,
    OpRoll  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] run;
    logic [31:0] ls;
    logic [3:0]  etype;
    logic [63:0] tech;
    logic [63:0] dlow;
    logic [63:0] dhigh;
  } job_t;

endpackage

@@ rtl/core/lsts_front.sv @@
// Front end: accepts words, classifies them against the tracked open section.
// Depends on lsts_pkg.
module lsts_front import lsts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        enable_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command_i,
  input  logic [31:0] run_number_i,
  input  logic [31:0] ls_number_i,
  input  logic [3:0]  event_type_i,
  input  logic [63:0] technical_bits_i,
  input  logic [63:0] decision_low_bits_i,
  input  logic [63:0] decision_high_bits_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  logic        open_q, open_d;
  logic [31:0] ls_q, ls_d;
  logic        push;
  logic        emit;

  assign in_ready = job_ready_i;
  assign push = in_valid && in_ready;

  always_comb begin
    open_d = open_q;
    ls_d = ls_q;
    emit = 1'b0;
    job_o.op = OpCount;
    job_o.run = run_number_i;
    job_o.ls = ls_number_i;
    job_o.etype = event_type_i;
    job_o.tech = technical_bits_i;
    job_o.dlow = decision_low_bits_i;
    job_o.dhigh = decision_high_bits_i;
    if (command_i == CmdFlush) begin
      job_o.op = OpClose;
      emit = open_q;
      open_d = 1'b0;
    end else if (enable_i) begin
      emit = 1'b1;
      open_d = 1'b1;
      if (!open_q) begin
        job_o.op = OpOpen;
        ls_d = ls_number_i;
      end else if (ls_number_i > ls_q) begin
        job_o.op = OpRoll;
        ls_d = ls_number_i;
      end
    end
  end

  assign job_valid_o = in_valid && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      ls_q <= '0;
    end else if (push) begin
      open_q <= open_d;
      ls_q <= ls_d;
    end
  end

endmodule

@@ rtl/core/lsts_queue.sv @@
// Two-entry queue between the front end and the scaler engine.
// Depends on lsts_pkg.
module lsts_queue import lsts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) begin
        wp_q <= ~wp_q;
      end
      if (rd) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ rtl/core/lsts_engine.sv @@
// Scaler engine: walks the 64 counter entries per job, clearing or adding as it
// goes, and emits a closed record on close and roll jobs. Depends on lsts_pkg.
module lsts_engine import lsts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] record_run_o,
  output logic [31:0] record_ls_o,
  output logic [31:0] skipped_sections_o,
  output logic [31:0] event_total_o,
  output logic [31:0] physics_total_o,
  output logic [31:0] calibration_total_o,
  output logic [31:0] random_total_o,
  output logic [5:0]  bit_index_o,
  output logic [31:0] technical_count_o,
  output logic [31:0] decision_low_count_o,
  output logic [31:0] decision_high_count_o,
  output logic        last_of_record_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRead = 3'b010,
    StWalk = 3'b100
  } state_e;

  state_e      state_q;
  job_t        job_q;
  logic [IdxW-1:0] idx_q;
  logic        emit_q;

  logic [31:0] tmem [TrigBits];
  logic [31:0] lmem [TrigBits];
  logic [31:0] hmem [TrigBits];
  logic [31:0] t_rd_q, l_rd_q, h_rd_q;

  logic [31:0] run_q, ls_q, skip_q, ev_q, ph_q, ca_q, ra_q;
  logic        ovalid_q;
  logic        fresh;

  assign fresh = (job_q.op == OpOpen) || (job_q.op == OpRoll);
  assign job_ready_o = state_q == StIdle;

  always_ff @(posedge clk_i) begin
    if (state_q == StRead || (state_q == StWalk && !(ovalid_q && !out_ready)
        && idx_q != IdxW'(TrigBits - 1))) begin
      t_rd_q <= tmem[state_q == StRead ? idx_q : idx_q + 1'b1];
      l_rd_q <= lmem[state_q == StRead ? idx_q : idx_q + 1'b1];
      h_rd_q <= hmem[state_q == StRead ? idx_q : idx_q + 1'b1];
    end
    if (state_q == StWalk && !(ovalid_q && !out_ready)) begin
      tmem[idx_q] <= (fresh ? 32'd0 : t_rd_q) + {31'd0, job_q.tech[idx_q]};
      lmem[idx_q] <= (fresh ? 32'd0 : l_rd_q) + {31'd0, job_q.dlow[idx_q]};
      hmem[idx_q] <= (fresh ? 32'd0 : h_rd_q) + {31'd0, job_q.dhigh[idx_q]};
      if (emit_q) begin
        bit_index_o <= idx_q;
        technical_count_o <= t_rd_q;
        decision_low_count_o <= l_rd_q;
        decision_high_count_o <= h_rd_q;
        last_of_record_o <= idx_q == IdxW'(TrigBits - 1);
        record_run_o <= run_q;
        record_ls_o <= ls_q;
        skipped_sections_o <= skip_q;
        event_total_o <= ev_q;
        physics_total_o <= ph_q;
        calibration_total_o <= ca_q;
        random_total_o <= ra_q;
      end
    end
  end

  assign out_valid = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      emit_q <= 1'b0;
      ovalid_q <= 1'b0;
      job_q <= '0;
      run_q <= '0;
      ls_q <= '0;
      skip_q <= '0;
      ev_q <= '0;
      ph_q <= '0;
      ca_q <= '0;
      ra_q <= '0;
    end else begin
      if (ovalid_q && out_ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            job_q <= job_i;
            idx_q <= '0;
            emit_q <= (job_i.op == OpClose) || (job_i.op == OpRoll);
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StWalk;
        end
        StWalk: begin
          if (!(ovalid_q && !out_ready)) begin
            if (emit_q) begin
              ovalid_q <= 1'b1;
            end
            if (idx_q == IdxW'(TrigBits - 1)) begin
              state_q <= StIdle;
              if (job_q.op != OpClose) begin
                run_q <= fresh ? job_q.run : run_q;
                ls_q <= fresh ? job_q.ls : ls_q;
                skip_q <= job_q.op == OpOpen ? job_q.ls - 32'd1 :
                          job_q.op == OpRoll ? job_q.ls - ls_q - 32'd1 : skip_q;
                ev_q <= (fresh ? 32'd0 : ev_q) + 32'd1;
                ph_q <= (fresh ? 32'd0 : ph_q) +
                        {31'd0, job_q.etype == TypePhysics};
                ca_q <= (fresh ? 32'd0 : ca_q) +
                        {31'd0, job_q.etype == TypeCalibration};
                ra_q <= (fresh ? 32'd0 : ra_q) +
                        {31'd0, job_q.etype == TypeRandom};
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ rtl/core/lumi_section_trigger_scaler_bank.sv @@
// Luminosity-section trigger scaler bank, top level.
// An event word is taken from the queue into the engine, read ahead, then walked one
// counter entry per cycle over the counter memories; output stalls hold the walk.
// A closing event, or a flush while a record is open, delivers 64 result words over
// that walk, the first registered by the first walk step after the read-ahead state.
// Reset (asynchronous, active low) leaves no record open and counting enabled.
module lumi_section_trigger_scaler_bank import lsts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        enable_counting_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command_i,
  input  logic [31:0] run_number_i,
  input  logic [31:0] ls_number_i,
  input  logic [3:0]  event_type_i,
  input  logic [63:0] technical_bits_i,
  input  logic [63:0] decision_low_bits_i,
  input  logic [63:0] decision_high_bits_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] record_run_o,
  output logic [31:0] record_ls_o,
  output logic [31:0] skipped_sections_o,
  output logic [31:0] event_total_o,
  output logic [31:0] physics_total_o,
  output logic [31:0] calibration_total_o,
  output logic [31:0] random_total_o,
  output logic [5:0]  bit_index_o,
  output logic [31:0] technical_count_o,
  output logic [31:0] decision_low_count_o,
  output logic [31:0] decision_high_count_o,
  output logic        last_of_record_o
);

  logic enable_q;
  logic fq_valid, fq_ready, qe_valid, qe_ready;
  job_t fq_job, qe_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_valid) begin
      enable_q <= enable_counting_i;
    end
  end

  lsts_front u_front (
    .clk_i, .rst_ni, .enable_i(enable_q), .in_valid, .in_ready,
    .command_i, .run_number_i, .ls_number_i, .event_type_i,
    .technical_bits_i, .decision_low_bits_i, .decision_high_bits_i,
    .job_valid_o(fq_valid), .job_ready_i(fq_ready), .job_o(fq_job)
  );

  lsts_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_job),
    .rd_valid_o(qe_valid), .rd_ready_i(qe_ready), .rd_data_o(qe_job)
  );

  lsts_engine u_engine (
    .clk_i, .rst_ni, .job_valid_i(qe_valid), .job_ready_o(qe_ready), .job_i(qe_job),
    .out_valid, .out_ready, .record_run_o, .record_ls_o, .skipped_sections_o,
    .event_total_o, .physics_total_o, .calibration_total_o, .random_total_o,
    .bit_index_o, .technical_count_o, .decision_low_count_o,
    .decision_high_count_o, .last_of_record_o
  );

endmodule

@@ tb/lumi_section_trigger_scaler_bank_tb.sv @@
// Self-checking testbench for the luminosity-section trigger scaler bank.
// Drives event and flush words, predicts the closed-record words and checks them.
// Depends on lsts_pkg and lumi_section_trigger_scaler_bank.
`timescale 1ns / 1ps

module lumi_section_trigger_scaler_bank_tb;
  import lsts_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [31:0] run;
    logic [31:0] ls;
    logic [3:0]  etype;
    logic [63:0] tech;
    logic [63:0] dlow;
    logic [63:0] dhigh;
  } event_t;

  typedef struct packed {
    logic [31:0] run;
    logic [31:0] ls;
    logic [31:0] skipped;
    logic [31:0] events;
    logic [31:0] physics;
    logic [31:0] calibration;
    logic [31:0] randoms;
    logic [5:0]  bit_idx;
    logic [31:0] tech_cnt;
    logic [31:0] dlow_cnt;
    logic [31:0] dhigh_cnt;
    logic        last;
  } record_word_t;

  class scaler_scoreboard;
    record_word_t closed_words[$];
    bit           counting_on = 1'b1;
    bit           rec_open;
    logic [31:0]  rec_run, rec_ls, rec_skipped;
    logic [31:0]  n_events, n_physics, n_calibration, n_random;
    logic [31:0]  tech_sum[TrigBits];
    logic [31:0]  dlow_sum[TrigBits];
    logic [31:0]  dhigh_sum[TrigBits];
    int           errors;

    function void open_section(logic [31:0] run, logic [31:0] ls, logic [31:0] prev);
      rec_open = 1'b1;
      rec_run = run;
      rec_ls = ls;
      rec_skipped = ls - prev - 32'd1;
      n_events = '0;
      n_physics = '0;
      n_calibration = '0;
      n_random = '0;
      for (int i = 0; i < TrigBits; i++) begin
        tech_sum[i] = '0;
        dlow_sum[i] = '0;
        dhigh_sum[i] = '0;
      end
    endfunction

    function void close_section();
      record_word_t w;
      for (int i = 0; i < TrigBits; i++) begin
        w = '{rec_run, rec_ls, rec_skipped, n_events, n_physics, n_calibration,
              n_random, i[5:0], tech_sum[i], dlow_sum[i], dhigh_sum[i],
              (i == TrigBits - 1)};
        closed_words = {closed_words, w};
      end
    endfunction

    function void note_event(event_t ev);
      if (ev.cmd == CmdFlush) begin
        if (rec_open) close_section();
        rec_open = 1'b0;
        return;
      end
      if (!counting_on) return;
      if (!rec_open) begin
        open_section(ev.run, ev.ls, 32'd0);
      end else if (ev.ls > rec_ls) begin
        close_section();
        open_section(ev.run, ev.ls, rec_ls);
      end
      n_events += 32'd1;
      if (ev.etype == TypePhysics) n_physics += 32'd1;
      else if (ev.etype == TypeCalibration) n_calibration += 32'd1;
      else if (ev.etype == TypeRandom) n_random += 32'd1;
      for (int i = 0; i < TrigBits; i++) begin
        if (ev.tech[i]) tech_sum[i] += 32'd1;
        if (ev.dlow[i]) dlow_sum[i] += 32'd1;
        if (ev.dhigh[i]) dhigh_sum[i] += 32'd1;
      end
    endfunction

    function void check_word(record_word_t got);
      record_word_t want;
      if (closed_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected record word: %p", got);
        return;
      end
      want = closed_words.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("record word mismatch\n  expected %p\n  actual   %p",
                                   want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid, cfg_ready, enable_counting_i;
  logic        in_valid, in_ready;
  logic        command_i;
  logic [31:0] run_number_i, ls_number_i;
  logic [3:0]  event_type_i;
  logic [63:0] technical_bits_i, decision_low_bits_i, decision_high_bits_i;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] record_run_o, record_ls_o, skipped_sections_o, event_total_o;
  logic [31:0] physics_total_o, calibration_total_o, random_total_o;
  logic [5:0]  bit_index_o;
  logic [31:0] technical_count_o, decision_low_count_o, decision_high_count_o;
  logic        last_of_record_o;

  scaler_scoreboard sb = new();
  bit               no_gaps;
  int               quiet_cycles = 0;
  logic [31:0]      cur_run, cur_ls;

  always #4 clk_i = ~clk_i;

  lumi_section_trigger_scaler_bank i_dut (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .enable_counting_i,
    .in_valid, .in_ready, .command_i, .run_number_i, .ls_number_i, .event_type_i,
    .technical_bits_i, .decision_low_bits_i, .decision_high_bits_i,
    .out_valid, .out_ready, .record_run_o, .record_ls_o, .skipped_sections_o,
    .event_total_o, .physics_total_o, .calibration_total_o, .random_total_o,
    .bit_index_o, .technical_count_o, .decision_low_count_o,
    .decision_high_count_o, .last_of_record_o
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_word('{record_run_o, record_ls_o, skipped_sections_o, event_total_o,
                      physics_total_o, calibration_total_o, random_total_o, bit_index_o,
                      technical_count_o, decision_low_count_o, decision_high_count_o,
                      last_of_record_o});
    end
  end

  always @(posedge clk_i) begin
    out_ready <= (pick_gap() == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
        $display("[lumi_section_trigger_scaler_bank] ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(event_t ev);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command_i <= ev.cmd;
    run_number_i <= ev.run;
    ls_number_i <= ev.ls;
    event_type_i <= ev.etype;
    technical_bits_i <= ev.tech;
    decision_low_bits_i <= ev.dlow;
    decision_high_bits_i <= ev.dhigh;
    do @(posedge clk_i); while (!in_ready);
    sb.note_event(ev);
  endtask

  task automatic send_count(logic [31:0] run, logic [31:0] ls, logic [3:0] etype,
                            logic [63:0] tech, logic [63:0] dlow, logic [63:0] dhigh);
    send_word('{CmdCount, run, ls, etype, tech, dlow, dhigh});
  endtask

  task automatic send_flush();
    send_word('{CmdFlush, $urandom, $urandom, 4'($urandom), rand_word(), rand_word(),
                rand_word()});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.closed_words.size() != 0) @(posedge clk_i);
    repeat (240) @(posedge clk_i);
  endtask

  task automatic write_enable(logic value);
    drain();
    cfg_valid <= 1'b1;
    enable_counting_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    sb.counting_on = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_words(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_flush();
      end else if (r < 13) begin
        send_count($urandom, $urandom, 4'($urandom), rand_word(), rand_word(), rand_word());
      end else begin
        if (r < 20) cur_ls += $urandom_range(1, 3);
        else if (r < 24) cur_ls -= $urandom_range(1, 2);
        if (r == 99) cur_run = $urandom;
        send_count(cur_run, cur_ls, 4'($urandom_range(0, 15)), rand_word(), rand_word(),
                   rand_word());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    enable_counting_i = 1'b1;
    in_valid = 1'b0;
    command_i = CmdCount;
    run_number_i = '0;
    ls_number_i = '0;
    event_type_i = '0;
    technical_bits_i = '0;
    decision_low_bits_i = '0;
    decision_high_bits_i = '0;
    no_gaps = 1'b0;
    cur_run = 32'd7;
    cur_ls = 32'd10;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_flush();
    send_count(32'd0, 32'd0, TypePhysics, '1, '0, '1);
    send_count(32'd5, 32'd0, TypeCalibration, '0, '1, '0);
    send_flush();
    send_count('1, '1, TypeRandom, '1, '1, '1);
    send_count(32'd1, 32'd3, 4'd0, 64'h1, 64'h8000_0000_0000_0000, 64'hA5A5);
    send_count(32'd1, 32'd4, 4'd15, 64'h8000_0000_0000_0000, 64'h1, '1);
    send_count(32'd2, 32'd4, TypePhysics, '1, '1, '0);
    send_count(32'd2, 32'd2, TypeCalibration, '0, '1, '1);
    send_count(32'd3, 32'd9, TypeRandom, 64'h5555, '1, '0);
    send_count(32'd3, 32'd9, 4'd4, '0, '0, '0);
    send_count(32'd3, 32'hFFFF_FFFF, 4'd8, '1, '0, '1);
    send_flush();
    send_flush();
    send_count(32'd4, 32'd1, TypePhysics, '1, '1, '1);

    write_enable(1'b0);
    send_count(32'd9, 32'd50, TypePhysics, '1, '1, '1);
    send_count(32'd9, 32'd1, TypeRandom, '1, '0, '1);
    send_flush();
    send_count(32'd9, 32'd60, TypePhysics, '1, '1, '1);
    send_flush();

    write_enable(1'b1);
    random_words(210);
    write_enable(1'b0);
    random_words(20);
    write_enable(1'b1);
    random_words(180);
    send_flush();

    drain();
    if (sb.errors == 0 && sb.closed_words.size() == 0) begin
      $display("[lumi_section_trigger_scaler_bank] OK");
    end else begin
      $display("[lumi_section_trigger_scaler_bank] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lsts_pkg.sv
rtl/core/lsts_front.sv
rtl/core/lsts_queue.sv
rtl/core/lsts_engine.sv
rtl/core/lumi_section_trigger_scaler_bank.sv
tb/lumi_section_trigger_scaler_bank_tb.sv
